// File: design/bir_pkg.sv
`default_nettype none
package bir_pkg;

  localparam int unsigned MAX_ROWS_DEF  = 64;
  localparam int unsigned MAX_COLS_DEF  = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned SIZE_W    = 7;
  localparam int unsigned STEP_W    = 23;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] ROWS_RST = 7'd64;
  localparam logic [SIZE_W-1:0] COLS_RST = 7'd64;
  localparam logic [STEP_W-1:0] STEP_RST = 23'd65536;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_ROWS = 2'd0,
    REG_SOURCE_COLS = 2'd1,
    REG_ROW_STEP    = 2'd2,
    REG_COL_STEP    = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic near_full;
  } queue_stat_t;

endpackage
`default_nettype wire

// File: design/bir_ram.sv
`default_nettype none
module bir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/bir_front.sv
`default_nettype none
module bir_front #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                cmd,
  input  logic [bir_pkg::POS_W-1:0]           row_pos,
  input  logic [bir_pkg::POS_W-1:0]           col_pos,
  input  logic [bir_pkg::PIX_W-1:0]           pixel_in,
  input  logic                                cfg_we,
  input  logic [bir_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bir_pkg::STEP_W-1:0]          cfg_data,
  output logic                                q_push,
  output logic [1 + $clog2(MAX_ROWS) + $clog2(MAX_COLS) + bir_pkg::PIX_W
                + 2*(FRAC_BITS+3) - 1:0]      q_data
);
  import bir_pkg::*;

  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int IDX_W  = POS_W + 1;
  localparam int PROD_W = IDX_W + STEP_W;
  localparam int K_W    = PROD_W - FRAC_BITS;
  localparam int D_W    = FRAC_BITS + 3;
  localparam logic [D_W-1:0] ONE_D = D_W'(1) << FRAC_BITS;
  localparam logic [D_W-1:0] TWO_D = D_W'(2) << FRAC_BITS;
  localparam logic [RW-1:0] ROWS_MAX_LAST = RW'(MAX_ROWS - 1);
  localparam logic [CW-1:0] COLS_MAX_LAST = CW'(MAX_COLS - 1);

  // configuration registers
  logic [SIZE_W-1:0] source_rows;
  logic [SIZE_W-1:0] source_cols;
  logic [STEP_W-1:0] row_step;
  logic [STEP_W-1:0] col_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_rows <= ROWS_RST;
      source_cols <= COLS_RST;
      row_step    <= STEP_RST;
      col_step    <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SOURCE_ROWS: source_rows <= cfg_data[SIZE_W-1:0];
        REG_SOURCE_COLS: source_cols <= cfg_data[SIZE_W-1:0];
        REG_ROW_STEP:    row_step    <= cfg_data;
        REG_COL_STEP:    col_step    <= cfg_data;
        default: ;
      endcase
    end
  end

  // last usable neighbor index, from the size clamped to [2,max]
  logic [RW-1:0] rows_last;
  logic [CW-1:0] cols_last;

  always_comb begin
    if (source_rows < SIZE_W'(2)) begin
      rows_last = RW'(1);
    end else if (32'(source_rows) > MAX_ROWS) begin
      rows_last = ROWS_MAX_LAST;
    end else begin
      rows_last = RW'(source_rows - SIZE_W'(1));
    end
    if (source_cols < SIZE_W'(2)) begin
      cols_last = CW'(1);
    end else if (32'(source_cols) > MAX_COLS) begin
      cols_last = COLS_MAX_LAST;
    end else begin
      cols_last = CW'(source_cols - SIZE_W'(1));
    end
  end

  // stage a: scale the output index
  logic              a_valid;
  cmd_t              a_cmd;
  logic [POS_W-1:0]  a_row;
  logic [POS_W-1:0]  a_col;
  logic [PIX_W-1:0]  a_pix;
  logic [PROD_W-1:0] a_rpos;
  logic [PROD_W-1:0] a_cpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_cmd  <= cmd_t'(cmd);
    a_row  <= row_pos;
    a_col  <= col_pos;
    a_pix  <= pixel_in;
    a_rpos <= PROD_W'(row_pos + IDX_W'(1)) * PROD_W'(row_step);
    a_cpos <= PROD_W'(col_pos + IDX_W'(1)) * PROD_W'(col_step);
  end

  // clamp integer part to [1,last], fraction may be negative or above one
  function automatic logic [K_W+D_W-1:0] locate(input logic [PROD_W-1:0] pos,
                                                input logic [K_W-1:0] last);
    logic [K_W-1:0]    k;
    logic [D_W-1:0]    d;
    logic [PROD_W-1:0] over;
    k    = pos[PROD_W-1:FRAC_BITS];
    over = pos - {last, {FRAC_BITS{1'b0}}};
    if (k == '0) begin
      k = K_W'(1);
      d = D_W'(pos[FRAC_BITS-1:0]) - ONE_D;
    end else if (k > last) begin
      k = last;
      d = (over > PROD_W'(TWO_D)) ? TWO_D : D_W'(over);
    end else begin
      d = D_W'(pos[FRAC_BITS-1:0]);
    end
    locate = {k, d};
  endfunction

  logic [K_W+D_W-1:0] row_loc;
  logic [K_W+D_W-1:0] col_loc;
  logic               wr_in_range;
  logic               is_write;
  logic [RW-1:0]      row_sel;
  logic [CW-1:0]      col_sel;
  logic [D_W-1:0]     dr;
  logic [D_W-1:0]     dc;

  always_comb begin
    row_loc     = locate(a_rpos, K_W'(rows_last));
    col_loc     = locate(a_cpos, K_W'(cols_last));
    wr_in_range = (32'(a_row) < MAX_ROWS) && (32'(a_col) < MAX_COLS);
    is_write    = (a_cmd == CMD_WRITE);
    dr          = row_loc[D_W-1:0];
    dc          = col_loc[D_W-1:0];
    if (is_write) begin
      row_sel = a_row[RW-1:0];
      col_sel = a_col[CW-1:0];
    end else begin
      row_sel = row_loc[D_W+RW-1:D_W];
      col_sel = col_loc[D_W+CW-1:D_W];
    end
  end

  // stage b: classified word into the queue, out-of-range writes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      q_push <= 1'b0;
    end else begin
      q_push <= a_valid && (!is_write || wr_in_range);
    end
  end

  always_ff @(posedge clk) begin
    q_data <= {is_write, row_sel, col_sel, a_pix, dr, dc};
  end

endmodule
`default_nettype wire

// File: design/bir_queue.sv
`default_nettype none
module bir_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output bir_pkg::queue_stat_t stat
);
  import bir_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_pop;

  assign do_pop   = pop && (count != '0);
  assign pop_data = slots[rd_ptr];

  always_comb begin
    stat.empty     = (count == '0);
    // two words can still be on their way from the front
    stat.near_full = (32'(count) >= DEPTH - 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: design/bir_back.sv
`default_nettype none
module bir_back #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bir_pkg::queue_stat_t                q_stat,
  input  logic [1 + $clog2(MAX_ROWS) + $clog2(MAX_COLS) + bir_pkg::PIX_W
                + 2*(FRAC_BITS+3) - 1:0]      q_data,
  output logic                                q_pop,
  output logic                                done,
  output logic [bir_pkg::PIX_W-1:0]           pixel_out,
  output logic                                saturated
);
  import bir_pkg::*;

  localparam int RW         = $clog2(MAX_ROWS);
  localparam int CW         = $clog2(MAX_COLS);
  localparam int D_W        = FRAC_BITS + 3;
  localparam int A_W        = FRAC_BITS + 11;
  localparam int V_W        = 2*FRAC_BITS + 15;
  localparam int BANK_ROWS  = (MAX_ROWS + 1) / 2;
  localparam int BANK_COLS  = (MAX_COLS + 1) / 2;
  localparam int BANK_DEPTH = BANK_ROWS * BANK_COLS;
  localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic signed [V_W-1:0] HALF = V_W'(1) <<< (2*FRAC_BITS - 1);

  // unpack queue word
  logic                 is_write;
  logic [RW-1:0]        row;
  logic [CW-1:0]        col;
  logic [PIX_W-1:0]     pix;
  logic [D_W-1:0]       dr;
  logic [D_W-1:0]       dc;

  assign {is_write, row, col, pix, dr, dc} = q_data;
  assign q_pop = !q_stat.empty;

  function automatic logic [BA_W-1:0] bank_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
    bank_addr = BA_W'((32'(r) >> 1) * BANK_COLS + (32'(c) >> 1));
  endfunction

  // four banks by row and column parity, so the four neighbors read at once
  logic [PIX_W-1:0] bank_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [RW-1:0] rd_row;
    logic [CW-1:0] rd_col;
    logic          bank_we;

    always_comb begin
      rd_row  = (row[0] == 1'(b >> 1)) ? row : row - RW'(1);
      rd_col  = (col[0] == 1'(b)) ? col : col - CW'(1);
      bank_we = q_pop && is_write && ({row[0], col[0]} == 2'(b));
    end

    bir_ram #(
      .WIDTH(PIX_W),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (bank_we),
      .waddr(bank_addr(row, col)),
      .wdata(pix),
      .raddr(bank_addr(rd_row, rd_col)),
      .rdata(bank_q[b])
    );
  end

  // stage 1: neighbors come out of the banks
  logic                  s1_valid;
  logic                  s1_r0;
  logic                  s1_c0;
  logic signed [D_W-1:0] s1_dr;
  logic signed [D_W-1:0] s1_dc;

  // stage 2: row blends
  logic                  s2_valid;
  logic signed [A_W-1:0] s2_al;
  logic signed [A_W-1:0] s2_ar;
  logic signed [D_W-1:0] s2_dc;

  // stage 3: column blend
  logic                  s3_valid;
  logic signed [V_W-1:0] s3_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= q_pop && !is_write;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      done     <= s3_valid;
    end
  end

  logic signed [PIX_W:0]   p1;
  logic signed [PIX_W:0]   p2;
  logic signed [PIX_W:0]   p3;
  logic signed [PIX_W:0]   p4;
  logic signed [PIX_W+1:0] dl;
  logic signed [PIX_W+1:0] dh;
  logic signed [A_W-1:0]   al_next;
  logic signed [A_W-1:0]   ar_next;
  logic signed [A_W:0]     dv;
  logic signed [V_W-1:0]   v_next;
  logic signed [V_W-1:0]   t;
  logic [V_W-2*FRAC_BITS-2:0] q_hi;
  logic [PIX_W-1:0]        pix_next;
  logic                    sat_next;

  always_comb begin
    p1      = $signed({1'b0, bank_q[{~s1_r0, ~s1_c0}]});
    p2      = $signed({1'b0, bank_q[{s1_r0, ~s1_c0}]});
    p3      = $signed({1'b0, bank_q[{~s1_r0, s1_c0}]});
    p4      = $signed({1'b0, bank_q[{s1_r0, s1_c0}]});
    dl      = (PIX_W+2)'(p2) - (PIX_W+2)'(p1);
    dh      = (PIX_W+2)'(p4) - (PIX_W+2)'(p3);
    al_next = (A_W'(p1) <<< FRAC_BITS) + A_W'(dl) * A_W'(s1_dr);
    ar_next = (A_W'(p3) <<< FRAC_BITS) + A_W'(dh) * A_W'(s1_dr);
  end

  always_comb begin
    dv     = (A_W+1)'(s2_ar) - (A_W+1)'(s2_al);
    v_next = (V_W'(s2_al) <<< FRAC_BITS) + V_W'(dv) * V_W'(s2_dc);
  end

  // round half up, then clip to the pixel range
  always_comb begin
    t    = s3_v + HALF;
    q_hi = t[V_W-2:2*FRAC_BITS];
    if (t[V_W-1]) begin
      pix_next = '0;
      sat_next = 1'b1;
    end else if (q_hi > (V_W-2*FRAC_BITS-1)'(255)) begin
      pix_next = '1;
      sat_next = 1'b1;
    end else begin
      pix_next = q_hi[PIX_W-1:0];
      sat_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s1_r0     <= row[0];
    s1_c0     <= col[0];
    s1_dr     <= $signed(dr);
    s1_dc     <= $signed(dc);
    s2_al     <= al_next;
    s2_ar     <= ar_next;
    s2_dc     <= s1_dc;
    s3_v      <= v_next;
    pixel_out <= pix_next;
    saturated <= sat_next;
  end

endmodule
`default_nettype wire

// File: design/bilinear_image_resize.sv
`default_nettype none
// channel   direction  handshake              word
// ------    ---------  ---------------------  --------------------------------
// item      in         start & !busy          cmd, row_pos, col_pos, pixel_in
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
// result    out        done (one cycle)       pixel_out, saturated
//
// one item per clock while busy is low; a compute item passes the index multiply,
// classify, queue, bank read, row blend, column blend and clip registers before
// done rises with its word. write items give no result.
// rst is synchronous; busy is high during reset, the frame memory is not cleared.
// the back end drains the queue every cycle, so busy stays low in normal running.
// cfg_ready is always high.
module bilinear_image_resize #(
  parameter int MAX_ROWS  = bir_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = bir_pkg::MAX_COLS_DEF,
  parameter int FRAC_BITS = bir_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [bir_pkg::POS_W-1:0]     row_pos,
  input  logic [bir_pkg::POS_W-1:0]     col_pos,
  input  logic [bir_pkg::PIX_W-1:0]     pixel_in,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bir_pkg::STEP_W-1:0]    cfg_data,
  output logic                          done,
  output logic [bir_pkg::PIX_W-1:0]     pixel_out,
  output logic                          saturated
);
  import bir_pkg::*;

  localparam int QD_W = 1 + $clog2(MAX_ROWS) + $clog2(MAX_COLS) + PIX_W + 2*(FRAC_BITS+3);

  logic            q_push;
  logic [QD_W-1:0] q_push_data;
  logic            q_pop;
  logic [QD_W-1:0] q_pop_data;
  queue_stat_t     q_stat;

  assign busy      = rst || q_stat.near_full;
  assign cfg_ready = 1'b1;

  bir_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .cmd      (cmd),
    .row_pos  (row_pos),
    .col_pos  (col_pos),
    .pixel_in (pixel_in),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  bir_queue #(
    .WIDTH(QD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .stat     (q_stat)
  );

  bir_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .q_data   (q_pop_data),
    .q_pop    (q_pop),
    .done     (done),
    .pixel_out(pixel_out),
    .saturated(saturated)
  );

endmodule
`default_nettype wire

// File: design/bir_checker.sv
`default_nettype none
module bir_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      cmd,
  input logic                      done,
  input logic [bir_pkg::PIX_W-1:0] pixel_out,
  input logic                      saturated
);
  import bir_pkg::*;

  localparam int LATENCY = 7;

  logic compute_accept;
  assign compute_accept = start && !busy && (cmd == CMD_COMPUTE);

  // clipped results sit at one end of the range
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> (pixel_out == '0) || (pixel_out == '1))
    else $error("saturated result not at a range end");

  a_compute_gives_result: assert property (@(posedge clk) disable iff (rst)
    compute_accept |-> ##LATENCY done)
    else $error("compute word gave no result");

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(compute_accept, LATENCY))
    else $error("result without a compute word");

  a_busy_in_reset: assert property (@(posedge clk)
    rst |-> busy)
    else $error("busy low during reset");

endmodule

bind bilinear_image_resize bir_checker u_checker (.*);
`default_nettype wire

// File: bench/testbench.sv
module testbench;
  import bir_pkg::*;

  localparam int unsigned MAX_ROWS       = MAX_ROWS_DEF;
  localparam int unsigned MAX_COLS       = MAX_COLS_DEF;
  localparam int unsigned FRAC           = FRAC_BITS_DEF;
  localparam int unsigned STORE_DEPTH    = MAX_ROWS * MAX_COLS;
  localparam longint      ONE            = longint'(1) << FRAC;
  localparam int unsigned RESULT_LATENCY = 7;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS    = 240;
  localparam int unsigned CYCLE_LIMIT    = 300000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             sat;
  } resized_pixel_t;

  class resize_scoreboard;
    logic [PIX_W-1:0]  frame [STORE_DEPTH];
    bit                written [STORE_DEPTH];
    logic [SIZE_W-1:0] rows_reg;
    logic [SIZE_W-1:0] cols_reg;
    logic [STEP_W-1:0] row_step_reg;
    logic [STEP_W-1:0] col_step_reg;
    resized_pixel_t    expected_q[$];
    int                errors;
    int                results_seen;

    function new();
      rows_reg     = ROWS_RST;
      cols_reg     = COLS_RST;
      row_step_reg = STEP_RST;
      col_step_reg = STEP_RST;
      errors       = 0;
      results_seen = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [STEP_W-1:0] data);
      case (idx)
        REG_SOURCE_ROWS: rows_reg     = data[SIZE_W-1:0];
        REG_SOURCE_COLS: cols_reg     = data[SIZE_W-1:0];
        REG_ROW_STEP:    row_step_reg = data;
        REG_COL_STEP:    col_step_reg = data;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned maxv);
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return v;
    endfunction

    // integer part clamped to [1,n-1], signed fraction capped at two
    function void locate(input logic [POS_W-1:0] idx, input logic [STEP_W-1:0] step,
                         input int unsigned n, output int unsigned k, output longint frac);
      logic [63:0] pos;
      logic [63:0] ip;
      pos = (64'(idx) + 64'd1) * 64'(step);
      ip = pos >> FRAC;
      if (ip < 64'd1) ip = 64'd1;
      if (ip > 64'(n - 1)) ip = 64'(n - 1);
      frac = longint'(pos) - longint'(ip << FRAC);
      if (frac > 2 * ONE) frac = 2 * ONE;
      k = int'(ip);
    endfunction

    function void corners(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col,
                          output int unsigned r, output int unsigned c);
      longint unused;
      locate(row, row_step_reg, clamp_size(rows_reg, MAX_ROWS), r, unused);
      locate(col, col_step_reg, clamp_size(cols_reg, MAX_COLS), c, unused);
    endfunction

    function longint pixel_at(int unsigned r, int unsigned c);
      return longint'(frame[r * MAX_COLS + c]);
    endfunction

    function void note_item(cmd_t op, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                            logic [PIX_W-1:0] pix);
      int unsigned r, c;
      longint dr, dc, p1, p2, p3, p4, al, ar, v, t, q;
      resized_pixel_t want;
      if (op == CMD_WRITE) begin
        if (row < MAX_ROWS && col < MAX_COLS) begin
          frame[row * MAX_COLS + col]   = pix;
          written[row * MAX_COLS + col] = 1'b1;
        end
        return;
      end
      locate(row, row_step_reg, clamp_size(rows_reg, MAX_ROWS), r, dr);
      locate(col, col_step_reg, clamp_size(cols_reg, MAX_COLS), c, dc);
      p1 = pixel_at(r - 1, c - 1);
      p2 = pixel_at(r, c - 1);
      p3 = pixel_at(r - 1, c);
      p4 = pixel_at(r, c);
      al = p1 * ONE + (p2 - p1) * dr;
      ar = p3 * ONE + (p4 - p3) * dr;
      v  = al * ONE + (ar - al) * dc;
      t  = v + (longint'(1) << (2 * FRAC - 1));
      want.sat = 1'b0;
      if (t < 0) begin
        q = 0;
        want.sat = 1'b1;
      end else begin
        q = t >>> (2 * FRAC);
        if (q > 255) begin
          q = 255;
          want.sat = 1'b1;
        end
      end
      want.pixel = q[PIX_W-1:0];
      expected_q.push_back(want);
    endfunction

    task report(string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task check(logic [PIX_W-1:0] pix, logic sat);
      resized_pixel_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word pixel_out=%0d saturated=%0b", pix, sat));
        return;
      end
      want = expected_q.pop_front();
      if (pix !== want.pixel)
        report($sformatf("pixel_out %0d, expected %0d", pix, want.pixel));
      if (sat !== want.sat)
        report($sformatf("saturated %0b, expected %0b", sat, want.sat));
      results_seen++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 cmd;
  logic [POS_W-1:0]     row_pos;
  logic [POS_W-1:0]     col_pos;
  logic [PIX_W-1:0]     pixel_in;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [STEP_W-1:0]    cfg_data;
  logic                 done;
  logic [PIX_W-1:0]     pixel_out;
  logic                 saturated;

  resize_scoreboard sb;
  int unsigned      idle_pct;
  int unsigned      item_count;
  int unsigned      cycle_count;

  bilinear_image_resize u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .row_pos   (row_pos),
    .col_pos   (col_pos),
    .pixel_in  (pixel_in),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .pixel_out (pixel_out),
    .saturated (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(pixel_out, saturated);
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_item(cmd_t op, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                           logic [PIX_W-1:0] pix);
    int unsigned gap;
    gap = (idle_pct != 0 && $urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    cmd      <= op;
    row_pos  <= row;
    col_pos  <= col;
    pixel_in <= pix;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(op, row, col, pix);
    item_count++;
  endtask

  task automatic fill_pixel(int unsigned r, int unsigned c);
    if (!sb.written[r * MAX_COLS + c])
      send_item(CMD_WRITE, POS_W'(r), POS_W'(c), pick_pixel());
  endtask

  // make sure all four neighbors hold data before the compute word goes in
  task automatic compute_pixel(logic [POS_W-1:0] row, logic [POS_W-1:0] col);
    int unsigned r, c;
    sb.corners(row, col, r, c);
    fill_pixel(r - 1, c - 1);
    fill_pixel(r, c - 1);
    fill_pixel(r - 1, c);
    fill_pixel(r, c);
    send_item(CMD_COMPUTE, row, col, PIX_W'($urandom_range(255)));
  endtask

  task automatic wait_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_results();
    repeat (RESULT_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [STEP_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [STEP_W-1:0] rows, logic [STEP_W-1:0] cols,
                           logic [STEP_W-1:0] rstep, logic [STEP_W-1:0] cstep);
    settle();
    write_reg(REG_SOURCE_ROWS, rows);
    write_reg(REG_SOURCE_COLS, cols);
    write_reg(REG_ROW_STEP, rstep);
    write_reg(REG_COL_STEP, cstep);
  endtask

  task automatic run_phase(int unsigned phase);
    int unsigned rows_v, cols_v, out_r, out_c, n_r, n_c, first, sel;
    logic [STEP_W-1:0] rows_data, cols_data, rstep, cstep;
    bit paused;
    rows_v = (phase == 1) ? 64 : (phase == 2) ? 2 : $urandom_range(2, 64);
    cols_v = (phase == 2) ? 64 : (phase == 1) ? 2 : $urandom_range(2, 64);
    out_r  = $urandom_range(1, 2 * rows_v);
    out_c  = $urandom_range(1, 2 * cols_v);
    rstep  = STEP_W'((rows_v << FRAC) / out_r);
    cstep  = STEP_W'((cols_v << FRAC) / out_c);
    if ($urandom_range(5) == 0) begin
      rstep = STEP_W'($urandom_range(0, 23'h7FFFFF));
      out_r = 1023;
    end
    if ($urandom_range(5) == 0) begin
      cstep = STEP_W'($urandom_range(0, 23'h7FFFFF));
      out_c = 1023;
    end
    // upper data bits are not part of the size registers
    rows_data = STEP_W'(rows_v) |
                (($urandom_range(3) == 0) ? (23'h7FFF80 & STEP_W'($urandom)) : '0);
    cols_data = STEP_W'(cols_v) |
                (($urandom_range(3) == 0) ? (23'h7FFF80 & STEP_W'($urandom)) : '0);
    configure(rows_data, cols_data, rstep, cstep);
    idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 48 : 26;
    n_r    = sb.clamp_size(sb.rows_reg, MAX_ROWS);
    n_c    = sb.clamp_size(sb.cols_reg, MAX_COLS);
    first  = item_count;
    paused = 1'b0;
    while (item_count - first < PHASE_ITEMS) begin
      if (!paused && item_count - first >= PHASE_ITEMS / 2) begin
        wait_results();
        paused = 1'b1;
      end
      sel = $urandom_range(99);
      if (sel < 45)
        send_item(CMD_WRITE, POS_W'($urandom_range(n_r - 1)), POS_W'($urandom_range(n_c - 1)),
                  pick_pixel());
      else if (sel < 55)
        send_item(CMD_WRITE, POS_W'($urandom_range(1023)), POS_W'($urandom_range(1023)),
                  pick_pixel());
      else if (sel < 90)
        compute_pixel(POS_W'($urandom_range(out_r)), POS_W'($urandom_range(out_c)));
      else
        compute_pixel(POS_W'($urandom_range(1023)), POS_W'($urandom_range(1023)));
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = CMD_WRITE;
    row_pos    = '0;
    col_pos    = '0;
    pixel_in   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_SOURCE_ROWS;
    cfg_data   = '0;
    idle_pct   = 0;
    item_count = 0;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // checkerboard of extremes at the origin, then writes outside the store
    send_item(CMD_WRITE, 0, 0, 8'd255);
    send_item(CMD_WRITE, 1, 0, 8'd0);
    send_item(CMD_WRITE, 0, 1, 8'd0);
    send_item(CMD_WRITE, 1, 1, 8'd255);
    send_item(CMD_WRITE, 10'd64, 10'd0, 8'd255);
    send_item(CMD_WRITE, 10'd0, 10'd64, 8'd255);
    send_item(CMD_WRITE, 10'd1023, 10'd1023, 8'd255);

    // tiny step: negative fractions, extrapolation and clipping
    configure(2, 2, 256, 256);
    compute_pixel(0, 0);
    compute_pixel(10'd1023, 10'd1023);
    compute_pixel(0, 10'd1023);

    // zero step
    configure(2, 2, 0, 0);
    compute_pixel(5, 7);

    // sizes below range, largest steps push the fraction past its cap
    configure(0, 1, 23'd4194304, 23'h7FFFFF);
    compute_pixel(0, 0);
    compute_pixel(10'd1023, 10'd1023);

    // sizes above range
    configure(23'h7FFFFF, 127, 23'd65536, 23'd65536);
    compute_pixel(10, 20);
    compute_pixel(63, 63);

    for (int unsigned p = 0; p < NUM_PHASES; p++) run_phase(p);

    settle();
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
